/* hw/rtl/asn_pkg.sv */
// Shared widths, payload types, op codes and bit-count helpers for the neighbor counter.
`default_nettype none
package asn_pkg;

  localparam int unsigned NODE_W    = 6;
  localparam int unsigned NODE_SPAN = 64;
  localparam int unsigned NODES_DEF = 64;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned PC_W      = 5;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_COUNT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] common_count;
  } out_t;

  typedef struct packed {
    logic              is_query;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] limit;
  } cmd_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  function automatic logic [PC_W-1:0] popcount16(input logic [CHUNK_W-1:0] v);
    return {1'b0, popcount8(v[7:0])} + {1'b0, popcount8(v[15:8])};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/asn_stream_if.sv */
// Valid/ready stream interface carrying one payload word.
`default_nettype none
interface asn_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/adjacency_set_common_neighbor_count.sv */
// Top level: directed adjacency bit matrix with common-neighbor counting.
//
// Usage: words enter on in_i (valid/ready) with op, node_a and node_b. An add
// (op 0) sets bit node_b of row node_a and returns nothing; adds naming a node
// at or above NODES are dropped in the front end. A count (op 1) returns one
// word on out_o holding the number of nodes below min(node_a, node_b) present
// in both rows; a node at or above NODES gives 0.
// Flow: the front end queues up to two commands. The back end takes an add
// as a row read, then a write back. A count reads both rows, masks them,
// runs one 16-bit popcount per cycle over ceil(R/16) chunks of 16 bits,
// with R = min(NODES, 64), and then loads the result register.
// Reset: all rows read as empty through per-row valid bits cleared at reset;
// the queue and the output register are emptied. No clearing pass is needed.
// Stall: the result waits in the output register; the back end keeps taking
// adds and holds a finished count until the register frees, and in_i drops
// ready once the queue is full.
`default_nettype none
module adjacency_set_common_neighbor_count #(
  parameter int unsigned NODES = asn_pkg::NODES_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  asn_stream_if.sink   in_i,
  asn_stream_if.source out_o
);

  asn_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  asn_front #(
    .NODES (NODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  asn_back #(
    .NODES (NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/asn_front.sv */
// Front end: accepts words, range-checks and classifies them, queues commands.
`default_nettype none
module asn_front #(
  parameter int unsigned NODES = asn_pkg::NODES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  asn_stream_if.sink         in_i,
  output asn_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i
);

  localparam int unsigned ROWS = (NODES < asn_pkg::NODE_SPAN) ? NODES : asn_pkg::NODE_SPAN;
  localparam int unsigned CW   = asn_pkg::NODE_W + 1;

  asn_pkg::cmd_t fifo_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          accept, push, a_ok, b_ok, in_range;
  asn_pkg::cmd_t cmd_new;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign accept      = in_i.valid && in_i.ready;
  assign a_ok        = {1'b0, in_i.data.node_a} < CW'(ROWS);
  assign b_ok        = {1'b0, in_i.data.node_b} < CW'(ROWS);
  assign in_range    = a_ok && b_ok;
  assign push        = accept && ((in_i.data.op == asn_pkg::OP_COUNT) || in_range);

  always_comb begin
    cmd_new.is_query = (in_i.data.op == asn_pkg::OP_COUNT);
    cmd_new.node_a   = in_i.data.node_a;
    cmd_new.node_b   = in_i.data.node_b;
    if (!in_range) begin
      cmd_new.limit = '0;
    end else if (in_i.data.node_a < in_i.data.node_b) begin
      cmd_new.limit = in_i.data.node_a;
    end else begin
      cmd_new.limit = in_i.data.node_b;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_new;
    end
  end

  assign cmd_o       = fifo_q[rptr_q];
  assign cmd_valid_o = (cnt_q != 2'd0);

endmodule
`default_nettype wire

/* hw/rtl/asn_back.sv */
// Back end: adjacency row memory, edge insert and masked common-neighbor count.
`default_nettype none
module asn_back #(
  parameter int unsigned NODES = asn_pkg::NODES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire asn_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  asn_stream_if.source       out_o
);

  localparam int unsigned ROWS  = (NODES < asn_pkg::NODE_SPAN) ? NODES : asn_pkg::NODE_SPAN;
  localparam int unsigned IDXW  = $clog2(ROWS);
  localparam int unsigned CW    = asn_pkg::NODE_W + 1;
  localparam int unsigned STEPS = (ROWS + asn_pkg::CHUNK_W - 1) / asn_pkg::CHUNK_W;
  localparam int unsigned PADW  = STEPS * asn_pkg::CHUNK_W;
  localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MASK,
    ST_COUNT,
    ST_RESULT
  } state_e;

  state_e          state_q;
  logic [SW-1:0]   step_q;
  logic            out_valid_q;
  asn_pkg::out_t   out_data_q;
  logic [ROWS-1:0] row_vld_q;
  logic [ROWS-1:0] rows_q [ROWS];
  logic [ROWS-1:0] ra_q, rb_q;
  logic            va_q, vb_q;
  asn_pkg::cmd_t   cmd_q;
  logic [PADW-1:0] both_q;
  logic [CW-1:0]   acc_q;

  logic            cmd_pop, out_free;
  logic [IDXW-1:0] a_idx, b_idx, wa_idx, wb_idx;
  logic [ROWS-1:0] row_a, row_b, mask, bit_sel;

  assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = cmd_pop;
  assign out_free  = !out_valid_q || out_o.ready;
  assign a_idx     = cmd_i.node_a[IDXW-1:0];
  assign b_idx     = cmd_i.node_b[IDXW-1:0];
  assign wa_idx    = cmd_q.node_a[IDXW-1:0];
  assign wb_idx    = cmd_q.node_b[IDXW-1:0];
  assign row_a     = va_q ? ra_q : '0;
  assign row_b     = vb_q ? rb_q : '0;
  assign bit_sel   = ROWS'(1) << wb_idx;

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      mask[i] = CW'(i) < {1'b0, cmd_q.limit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop) begin
            state_q <= cmd_i.is_query ? ST_MASK : ST_WRITE;
          end
        end
        ST_WRITE: begin
          row_vld_q[wa_idx] <= 1'b1;
          state_q           <= ST_IDLE;
        end
        ST_MASK: begin
          step_q  <= '0;
          state_q <= ST_COUNT;
        end
        ST_COUNT: begin
          step_q <= step_q + SW'(1);
          if (step_q == SW'(STEPS - 1)) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop) begin
      cmd_q <= cmd_i;
      ra_q  <= rows_q[a_idx];
      rb_q  <= rows_q[b_idx];
      va_q  <= row_vld_q[a_idx];
      vb_q  <= row_vld_q[b_idx];
    end
    if (state_q == ST_WRITE) begin
      rows_q[wa_idx] <= row_a | bit_sel;
    end
    if (state_q == ST_MASK) begin
      both_q <= PADW'(row_a & row_b & mask);
      acc_q  <= '0;
    end
    if (state_q == ST_COUNT) begin
      acc_q  <= acc_q + CW'(asn_pkg::popcount16(both_q[asn_pkg::CHUNK_W-1:0]));
      both_q <= both_q >> asn_pkg::CHUNK_W;
    end
    if ((state_q == ST_RESULT) && out_free) begin
      out_data_q.common_count <= acc_q[asn_pkg::NODE_W-1:0];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
`default_nettype wire

/* bench/adjacency_set_common_neighbor_count_test.sv */
// Self-checking bench for the adjacency bit matrix and its common-neighbor counter.
`timescale 1ns / 1ps
module adjacency_set_common_neighbor_count_test;

  localparam int unsigned NODE_LIMIT = asn_pkg::NODES_DEF;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned STUCK_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;

  asn_stream_if #(.data_t(asn_pkg::in_t)) in_if ();
  asn_stream_if #(.data_t(asn_pkg::out_t)) out_if ();

  adjacency_set_common_neighbor_count #(
    .NODES(NODE_LIMIT)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_i(in_if),
    .out_o(out_if)
  );

  always #5 clk = ~clk;

  logic [asn_pkg::NODE_SPAN-1:0] adj_rows [asn_pkg::NODE_SPAN];
  asn_pkg::in_t pending_words [$];
  logic [asn_pkg::NODE_W-1:0] expected_counts [$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int last_hold_at = -1;
  int stall_left = 0;
  int stuck_cycles = 0;

  function automatic logic [asn_pkg::NODE_W-1:0] shared_below_count(
      logic [asn_pkg::NODE_W-1:0] a, logic [asn_pkg::NODE_W-1:0] b);
    logic [asn_pkg::NODE_W-1:0] limit;
    logic [asn_pkg::NODE_SPAN-1:0] both;
    logic [asn_pkg::NODE_W-1:0] n;
    limit = (a < b) ? a : b;
    n = '0;
    if (int'(a) >= NODE_LIMIT || int'(b) >= NODE_LIMIT) begin
      return '0;
    end
    both = adj_rows[a] & adj_rows[b] & ((64'd1 << limit) - 64'd1);
    for (int i = 0; i < asn_pkg::NODE_SPAN; i++) begin
      n = n + {{(asn_pkg::NODE_W-1){1'b0}}, both[i]};
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors = errors + 1;
  endtask

  task automatic queue_word(input logic op, input int a, input int b);
    asn_pkg::in_t w;
    w.op = op;
    w.node_a = a[asn_pkg::NODE_W-1:0];
    w.node_b = b[asn_pkg::NODE_W-1:0];
    pending_words.push_back(w);
  endtask

  task automatic queue_random_mix(input int count);
    int lo;
    int span;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        lo = $urandom_range(63);
        span = $urandom_range(24, 3);
      end
      if ($urandom_range(99) < 10) begin
        queue_word(1'($urandom_range(1)), $urandom_range(63), $urandom_range(63));
      end else begin
        queue_word(($urandom_range(99) < 55) ? asn_pkg::OP_ADD : asn_pkg::OP_COUNT,
                   (lo + $urandom_range(span)) % asn_pkg::NODE_SPAN,
                   (lo + $urandom_range(span)) % asn_pkg::NODE_SPAN);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk or negedge rst_n) begin
    logic send_idle;
    send_idle = (words_sent < 380 || words_sent >= 520) && ($urandom_range(99) < 20);
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      for (int i = 0; i < asn_pkg::NODE_SPAN; i++) adj_rows[i] = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (in_if.data.op == asn_pkg::OP_ADD) begin
          if (int'(in_if.data.node_a) < NODE_LIMIT && int'(in_if.data.node_b) < NODE_LIMIT)
            adj_rows[in_if.data.node_a][in_if.data.node_b] = 1'b1;
        end else begin
          expected_counts.push_back(shared_below_count(in_if.data.node_a,
                                                       in_if.data.node_b));
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && !send_idle) begin
          in_if.valid <= 1'b1;
          in_if.data <= pending_words.pop_front();
          words_sent <= words_sent + 1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    logic [asn_pkg::NODE_W-1:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected count %0d", out_if.data.common_count));
        end else begin
          want = expected_counts.pop_front();
          if (out_if.data.common_count !== want)
            report_mismatch($sformatf("common_count %0d, want %0d",
                                      out_if.data.common_count, want));
        end
        results_seen <= results_seen + 1;
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if ((results_seen == 30 || results_seen == 250) &&
                   last_hold_at != results_seen) begin
        last_hold_at <= results_seen;
        stall_left <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (results_seen >= 100 && results_seen < 180) ||
                        ($urandom_range(99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int perm [63];
    int j;
    int t;
    rst_n = 1'b0;

    queue_word(asn_pkg::OP_COUNT, 0, 0);
    queue_word(asn_pkg::OP_COUNT, 63, 63);
    queue_word(asn_pkg::OP_ADD, 0, 0);
    queue_word(asn_pkg::OP_ADD, 0, 0);
    queue_word(asn_pkg::OP_ADD, 63, 63);
    queue_word(asn_pkg::OP_ADD, 5, 1);
    queue_word(asn_pkg::OP_ADD, 7, 1);
    queue_word(asn_pkg::OP_COUNT, 5, 7);
    queue_word(asn_pkg::OP_COUNT, 7, 5);
    queue_word(asn_pkg::OP_COUNT, 1, 5);
    queue_word(asn_pkg::OP_ADD, 5, 0);
    queue_word(asn_pkg::OP_ADD, 7, 0);
    queue_word(asn_pkg::OP_COUNT, 5, 7);
    queue_word(asn_pkg::OP_COUNT, 5, 5);
    queue_word(asn_pkg::OP_ADD, 5, 5);
    queue_word(asn_pkg::OP_ADD, 7, 5);
    queue_word(asn_pkg::OP_COUNT, 5, 5);
    queue_word(asn_pkg::OP_COUNT, 7, 7);
    queue_word(asn_pkg::OP_ADD, 63, 62);
    queue_word(asn_pkg::OP_ADD, 62, 62);
    queue_word(asn_pkg::OP_COUNT, 62, 63);
    queue_word(asn_pkg::OP_ADD, 63, 61);
    queue_word(asn_pkg::OP_ADD, 62, 61);
    queue_word(asn_pkg::OP_COUNT, 63, 62);
    queue_word(asn_pkg::OP_COUNT, 0, 63);
    queue_random_mix(300);

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait_drained();

    for (int i = 0; i < 63; i++) perm[i] = i;
    for (int i = 62; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < 63; i++) begin
      queue_word(asn_pkg::OP_ADD, 63, perm[i]);
      if ($urandom_range(1)) queue_word(asn_pkg::OP_ADD, 62, perm[i]);
      if (i % 8 == 7) begin
        queue_word(asn_pkg::OP_COUNT, 63, 63);
        queue_word(asn_pkg::OP_COUNT, 63, $urandom_range(63));
      end
    end
    queue_word(asn_pkg::OP_COUNT, 63, 63);
    queue_word(asn_pkg::OP_COUNT, 62, 63);
    queue_word(asn_pkg::OP_COUNT, 63, 62);
    queue_word(asn_pkg::OP_COUNT, 62, 62);
    queue_random_mix(300);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* adjacency_set_common_neighbor_count.f */
hw/rtl/asn_pkg.sv
hw/rtl/asn_stream_if.sv
hw/rtl/asn_front.sv
hw/rtl/asn_back.sv
hw/rtl/adjacency_set_common_neighbor_count.sv
bench/adjacency_set_common_neighbor_count_test.sv
